>>> sv/integer_value_interning_table_macros.svh
// ----------------------------------------------------------------------------
// Integer value interning table: assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef INTEGER_VALUE_INTERNING_TABLE_MACROS_SVH
`define INTEGER_VALUE_INTERNING_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IVIT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ivit: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define IVIT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ivit: next-cycle check failed");

`endif

>>> sv/ivit_pkg.sv
// ----------------------------------------------------------------------------
// Integer value interning table: package
// Field widths, status and command codes, and default sizes.
// ----------------------------------------------------------------------------
package ivit_pkg;

  localparam int NUM_ATTRS_DEF = 4;
  localparam int VALUES_PER_ATTR_DEF = 16;

  localparam int VALUE_W = 64;
  localparam int ATTR_W = 2;
  localparam int ID_W = 4;
  localparam int ST_W = 3;

  // Capacity registers, one per attribute code.
  localparam int CAP_REGS = 4;
  localparam int CAP_W = 5;
  localparam int CAP_IDX_W = 2;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_ASSIGN = 1'b1;

  typedef logic [CAP_W-1:0] cap_t;

  typedef enum logic [ST_W-1:0] {
    ST_FOUND       = 3'd0,
    ST_ASSIGNED    = 3'd1,
    ST_NOT_FOUND   = 3'd2,
    ST_CAP_REFUSED = 3'd3,
    ST_OVERFLOW    = 3'd4
  } status_t;

endpackage

>>> sv/ivit_ram.sv
// ----------------------------------------------------------------------------
// Integer value interning table: generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ivit_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/ivit_cfg.sv
// ----------------------------------------------------------------------------
// Integer value interning table: capacity registers
// APB-style register file holding one capacity limit per attribute.
// ----------------------------------------------------------------------------
module ivit_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ivit_pkg::ADDR_W-1:0]   paddr,
  input  logic [ivit_pkg::DATA_W-1:0]   pwdata,
  output logic [ivit_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output ivit_pkg::cap_t                cap_o [ivit_pkg::CAP_REGS]
);

  ivit_pkg::cap_t                    caps_r [ivit_pkg::CAP_REGS];
  logic [ivit_pkg::CAP_IDX_W-1:0]    reg_idx;
  logic                              wr_en;

  assign reg_idx = paddr[ivit_pkg::ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign prdata  = ivit_pkg::DATA_W'(caps_r[reg_idx]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ivit_pkg::CAP_REGS; i++) begin
        caps_r[i] <= ivit_pkg::CAP_RESET;
      end
    end else if (wr_en) begin
      caps_r[reg_idx] <= pwdata[ivit_pkg::CAP_W-1:0];
    end
  end

  assign cap_o = caps_r;

endmodule

>>> sv/ivit_engine.sv
// ----------------------------------------------------------------------------
// Integer value interning table: search engine
// Walks one attribute's stored values through the RAM, then decides.
// ----------------------------------------------------------------------------
module ivit_engine #(
  parameter int NUM_ATTRS       = ivit_pkg::NUM_ATTRS_DEF,
  parameter int VALUES_PER_ATTR = ivit_pkg::VALUES_PER_ATTR_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  in_cmd,
  input  logic [ivit_pkg::ATTR_W-1:0]           in_attr_id,
  input  logic signed [ivit_pkg::VALUE_W-1:0]   in_value,
  input  logic                                  in_always_assign,
  input  ivit_pkg::cap_t                        cap_i [ivit_pkg::CAP_REGS],
  output logic                                  ram_we,
  output logic [((NUM_ATTRS * VALUES_PER_ATTR > 1) ?
                 $clog2(NUM_ATTRS * VALUES_PER_ATTR) : 1)-1:0] ram_waddr,
  output logic [ivit_pkg::VALUE_W-1:0]          ram_wdata,
  output logic                                  ram_re,
  output logic [((NUM_ATTRS * VALUES_PER_ATTR > 1) ?
                 $clog2(NUM_ATTRS * VALUES_PER_ATTR) : 1)-1:0] ram_raddr,
  input  logic [ivit_pkg::VALUE_W-1:0]          ram_rdata,
  output logic                                  out_valid,
  output logic [ivit_pkg::ID_W-1:0]             out_id,
  output logic [ivit_pkg::ST_W-1:0]             out_status
);

  localparam int DEPTH = NUM_ATTRS * VALUES_PER_ATTR;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW    = $clog2(VALUES_PER_ATTR);
  localparam int CW    = $clog2(VALUES_PER_ATTR + 1);
  localparam int AIW   = (NUM_ATTRS > 1) ? $clog2(NUM_ATTRS) : 1;
  localparam int KW    = (CW > ivit_pkg::CAP_W) ? CW : ivit_pkg::CAP_W;
  localparam logic [AW-1:0] VPA_A = AW'(VALUES_PER_ATTR);
  localparam logic [CW-1:0] VPA_C = CW'(VALUES_PER_ATTR);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t                        state_r;
  logic                          cmd_r;
  logic [ivit_pkg::ATTR_W-1:0]   attr_r;
  logic [ivit_pkg::VALUE_W-1:0]  val_r;
  logic                          always_r;
  logic                          bad_r;
  logic [AW-1:0]                 base_r;
  logic [CW-1:0]                 cnt_r;
  logic [CW-1:0]                 rd_idx_r;
  logic                          cmp_vld_r;
  logic [IW-1:0]                 cmp_idx_r;
  logic [CW-1:0]                 counts_r [NUM_ATTRS];
  logic                          out_valid_r;
  logic [ivit_pkg::ID_W-1:0]     out_id_r;
  ivit_pkg::status_t             out_status_r;

  logic                          start_ok;
  logic                          in_bad;
  logic                          hit;
  logic                          more;
  logic                          miss;
  ivit_pkg::status_t             miss_status;

  assign start_ok = start && (state_r == S_IDLE);
  assign in_bad   = (int'(in_attr_id) >= NUM_ATTRS);
  assign hit      = cmp_vld_r && (ram_rdata == val_r);
  assign more     = (rd_idx_r < cnt_r);
  assign miss     = (state_r == S_SCAN) && !hit && !more;

  // Outcome of a search that found nothing; the checks run in priority order.
  always_comb begin
    if (bad_r || (cmd_r == ivit_pkg::CMD_LOOKUP)) begin
      miss_status = ivit_pkg::ST_NOT_FOUND;
    end else if (!always_r && (KW'(cnt_r) >= KW'(cap_i[attr_r]))) begin
      miss_status = ivit_pkg::ST_CAP_REFUSED;
    end else if (cnt_r >= VPA_C) begin
      miss_status = ivit_pkg::ST_OVERFLOW;
    end else begin
      miss_status = ivit_pkg::ST_ASSIGNED;
    end
  end

  assign ram_re    = (state_r == S_SCAN) && !hit && more;
  assign ram_raddr = base_r + AW'(rd_idx_r);
  assign ram_we    = miss && (miss_status == ivit_pkg::ST_ASSIGNED);
  assign ram_waddr = base_r + AW'(cnt_r);
  assign ram_wdata = val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_ATTRS; i++) begin
        counts_r[i] <= '0;
      end
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start_ok) begin
            cmd_r     <= in_cmd;
            attr_r    <= in_attr_id;
            val_r     <= in_value;
            always_r  <= in_always_assign;
            bad_r     <= in_bad;
            base_r    <= AW'(in_attr_id) * VPA_A;
            cnt_r     <= in_bad ? '0 : counts_r[AIW'(in_attr_id)];
            rd_idx_r  <= '0;
            cmp_vld_r <= 1'b0;
            state_r   <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (hit) begin
            out_valid_r  <= 1'b1;
            out_id_r     <= ivit_pkg::ID_W'(cmp_idx_r);
            out_status_r <= ivit_pkg::ST_FOUND;
            cmp_vld_r    <= 1'b0;
            state_r      <= S_IDLE;
          end else if (more) begin
            cmp_vld_r <= 1'b1;
            cmp_idx_r <= IW'(rd_idx_r);
            rd_idx_r  <= rd_idx_r + 1'b1;
          end else begin
            out_valid_r  <= 1'b1;
            out_status_r <= miss_status;
            cmp_vld_r    <= 1'b0;
            state_r      <= S_IDLE;
            if (miss_status == ivit_pkg::ST_ASSIGNED) begin
              out_id_r               <= ivit_pkg::ID_W'(cnt_r);
              counts_r[AIW'(attr_r)] <= cnt_r + 1'b1;
            end else begin
              out_id_r <= '0;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_id     = out_id_r;
  assign out_status = out_status_r;

endmodule

>>> sv/integer_value_interning_table.sv
// ----------------------------------------------------------------------------
// Integer value interning table: top level
// Dense per-attribute ids for 64-bit integer values, searched in RAM.
// ----------------------------------------------------------------------------
// Search: an item's search reads its attribute's stored values through the
//   single RAM read port, one stored value a cycle, and out_valid rises
//   once a match is found or the stored values run out; a new item is
//   accepted only while busy is low.
// Reset (rst_n low, synchronous) empties every attribute table, sets each
//   capacity register to 16 and drops busy and out_valid.
module integer_value_interning_table #(
  parameter int NUM_ATTRS       = ivit_pkg::NUM_ATTRS_DEF,
  parameter int VALUES_PER_ATTR = ivit_pkg::VALUES_PER_ATTR_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input item channel.
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_cmd,
  input  logic [ivit_pkg::ATTR_W-1:0]         in_attr_id,
  input  logic signed [ivit_pkg::VALUE_W-1:0] in_value,
  input  logic                                in_always_assign,
  // Result channel: one item per request, shown for a single cycle.
  output logic                                out_valid,
  output logic [ivit_pkg::ID_W-1:0]           out_id,
  output logic [ivit_pkg::ST_W-1:0]           out_status,
  // Configuration port holding the capacity registers.
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ivit_pkg::ADDR_W-1:0]         paddr,
  input  logic [ivit_pkg::DATA_W-1:0]         pwdata,
  output logic [ivit_pkg::DATA_W-1:0]         prdata,
  output logic                                pready
);

  // The value store holds every attribute's table back to back: attribute a
  // owns words a*VALUES_PER_ATTR onward. Only entries below the attribute's
  // count are ever read, so the store needs no clearing after reset.
  localparam int DEPTH = NUM_ATTRS * VALUES_PER_ATTR;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  ivit_pkg::cap_t                caps [ivit_pkg::CAP_REGS];
  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [ivit_pkg::VALUE_W-1:0]  ram_wdata;
  logic                          ram_re;
  logic [AW-1:0]                 ram_raddr;
  logic [ivit_pkg::VALUE_W-1:0]  ram_rdata;

  // Capacity limits. Software must write them only while the block is idle;
  // the block does not enforce this. The engine reads them directly in a search.
  ivit_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cap_o   (caps)
  );

  // The engine streams reads one per cycle, each word compared in the next
  // cycle. The first match in insertion order ends the search. An unrefused
  // assign miss appends the value at the attribute's count, written back in
  // the same cycle as the result is registered; the next item cannot start
  // its reads before that write lands, so no forwarding is needed.
  ivit_engine #(
    .NUM_ATTRS       (NUM_ATTRS),
    .VALUES_PER_ATTR (VALUES_PER_ATTR)
  ) u_engine (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_attr_id       (in_attr_id),
    .in_value         (in_value),
    .in_always_assign (in_always_assign),
    .cap_i            (caps),
    .ram_we           (ram_we),
    .ram_waddr        (ram_waddr),
    .ram_wdata        (ram_wdata),
    .ram_re           (ram_re),
    .ram_raddr        (ram_raddr),
    .ram_rdata        (ram_rdata),
    .out_valid        (out_valid),
    .out_id           (out_id),
    .out_status       (out_status)
  );

  ivit_ram #(
    .WIDTH (ivit_pkg::VALUE_W),
    .DEPTH (DEPTH)
  ) u_value_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

>>> sv/ivit_checker.sv
// ----------------------------------------------------------------------------
// Integer value interning table: port checker
// Watches the top-level handshake and result ports over time.
// ----------------------------------------------------------------------------
`include "integer_value_interning_table_macros.svh"

module ivit_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic                      out_valid,
  input logic [ivit_pkg::ID_W-1:0] out_id,
  input logic [ivit_pkg::ST_W-1:0] out_status
);

  // An accepted item keeps the block busy for at least the next cycle.
  `IVIT_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)

  // The result appears exactly when the block stops being busy.
  `IVIT_ASSERT_NOW(a_result_on_fall, clk, rst_n, $fell(busy), out_valid)

  // Results are single-cycle strobes and never shown while still searching.
  `IVIT_ASSERT_NEXT(a_single_strobe, clk, rst_n, out_valid, !out_valid)

  // Every status other than found or assigned carries id zero.
  `IVIT_ASSERT_NOW(a_invalid_id_zero, clk, rst_n,
    out_valid && (out_status != ivit_pkg::ST_FOUND) &&
    (out_status != ivit_pkg::ST_ASSIGNED), out_id == '0)

endmodule

bind integer_value_interning_table ivit_checker u_ivit_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_valid  (out_valid),
  .out_id     (out_id),
  .out_status (out_status)
);

>>> bench/interning_check_pkg.sv
// ----------------------------------------------------------------------------
// Interning table scoreboard
// Keeps a private copy of the attribute tables, counts and capacity limits,
// works out the id and status of every accepted item, and checks results.
// ----------------------------------------------------------------------------
package interning_check_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  import ivit_pkg::*;

  typedef struct packed {
    logic [ID_W-1:0] id;
    status_t         status;
  } intern_result_t;

  class interning_scoreboard;
    logic [VALUE_W-1:0] table_vals [NUM_ATTRS_DEF][VALUES_PER_ATTR_DEF];
    int unsigned        fill [NUM_ATTRS_DEF];
    cap_t               cap_limit [CAP_REGS];
    intern_result_t     awaited_ids [$];
    int unsigned        errors;

    function new();
      foreach (fill[a]) fill[a] = 0;
      foreach (cap_limit[i]) cap_limit[i] = CAP_RESET;
      errors = 0;
    endfunction

    // Works out the result of one accepted item and updates the tables.
    function void note_request(logic cmd, logic [ATTR_W-1:0] attr,
                               logic [VALUE_W-1:0] value, logic ignore_cap);
      intern_result_t r;
      int unsigned    cnt;
      bit             hit;
      r.id = '0;
      hit  = 1'b0;
      if (int'(attr) >= NUM_ATTRS_DEF) begin
        r.status = ST_NOT_FOUND;
      end else begin
        cnt = fill[attr];
        for (int j = 0; j < cnt && !hit; j++) begin
          if (table_vals[attr][j] == value) begin
            hit      = 1'b1;
            r.id     = ID_W'(j);
            r.status = ST_FOUND;
          end
        end
        if (!hit) begin
          if (cmd == CMD_LOOKUP) begin
            r.status = ST_NOT_FOUND;
          end else if (!ignore_cap && cnt >= cap_limit[attr]) begin
            // The capacity refusal wins over a full table.
            r.status = ST_CAP_REFUSED;
          end else if (cnt >= VALUES_PER_ATTR_DEF) begin
            r.status = ST_OVERFLOW;
          end else begin
            table_vals[attr][cnt] = value;
            fill[attr]            = cnt + 1;
            r.id                  = ID_W'(cnt);
            r.status              = ST_ASSIGNED;
          end
        end
      end
      awaited_ids.push_back(r);
    endfunction

    function void check_result(logic [ID_W-1:0] id, logic [ST_W-1:0] status);
      intern_result_t exp;
      if (awaited_ids.size() == 0) begin
        $display("%0t: result with nothing expected, id %0d status %0d",
                 $time, id, status);
        errors++;
      end else begin
        exp = awaited_ids.pop_front();
        if (id !== exp.id) begin
          $display("%0t: id mismatch, expected %0d actual %0d", $time, exp.id, id);
          errors++;
        end
        if (status !== exp.status) begin
          $display("%0t: status mismatch, expected %0d actual %0d",
                   $time, exp.status, status);
          errors++;
        end
      end
    endfunction
  endclass

endpackage

>>> bench/tb_integer_value_interning_table.sv
// ----------------------------------------------------------------------------
// Integer value interning table testbench
// Drives lookup and assign items through the start/busy port, sets the
// capacity registers over the APB-style port between phases, and checks
// every result strobe against a scoreboard that tracks the attribute tables.
// ----------------------------------------------------------------------------
module tb_integer_value_interning_table;
  timeunit 1ns;
  timeprecision 1ps;

  import ivit_pkg::*;
  import interning_check_pkg::*;

  localparam logic [VALUE_W-1:0] VAL_MIN = 64'h8000_0000_0000_0000;
  localparam logic [VALUE_W-1:0] VAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int PHASES = 5;
  localparam int PHASE_ITEMS = 190;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic               in_cmd;
  logic [ATTR_W-1:0]  in_attr_id;
  logic [VALUE_W-1:0] in_value;
  logic               in_always_assign;
  logic               out_valid;
  logic [ID_W-1:0]    out_id;
  logic [ST_W-1:0]    out_status;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  interning_scoreboard ledger = new();

  integer_value_interning_table DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_attr_id       (in_attr_id),
    .in_value         (in_value),
    .in_always_assign (in_always_assign),
    .out_valid        (out_valid),
    .out_id           (out_id),
    .out_status       (out_status),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The slowest correct run is about a thousand items, each a full search
  // plus a random sender gap, well under a quarter of this budget.
  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Results are shown for one cycle and cannot be held off, so every strobe
  // seen at a rising edge is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      ledger.check_result(out_id, out_status);
    end
  end

  // Presents one item and holds start high until an edge at which busy is
  // low. Raising start while the block is still busy is deliberate. After
  // acceptance the sender may go quiet for a random number of cycles; the
  // gap lengths are spread so that the next start falls at different points
  // of the search.
  task automatic send_item(input logic cmd, input logic [ATTR_W-1:0] attr,
                           input logic [VALUE_W-1:0] value, input logic aa,
                           input int idle_pct);
    start            <= 1'b1;
    in_cmd           <= cmd;
    in_attr_id       <= attr;
    in_value         <= value;
    in_always_assign <= aa;
    do @(posedge clk); while (busy);
    ledger.note_request(cmd, attr, value, aa);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Every item yields exactly one result, so once nothing is awaited and
  // busy is low the block is idle and the registers may be rewritten.
  task automatic wait_idle();
    start <= 1'b0;
    while (ledger.awaited_ids.size() != 0 || busy) @(posedge clk);
  endtask

  // Writes all four capacity registers back to back. psel stays high from
  // one write to the next; only penable drops for each setup cycle.
  task automatic write_caps(input cap_t caps [CAP_REGS]);
    for (int i = 0; i < CAP_REGS; i++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'(4 * i);
      pwdata  <= DATA_W'(caps[i]);
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      ledger.cap_limit[i] = caps[i];
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Random items. About half the values are taken from the attribute's own
  // table so that hits land at every index; some come from other attributes
  // (misses with plausible data), some are the field extremes, and the rest
  // are fresh 64-bit patterns that grow the tables until capacity or
  // storage stops them.
  task automatic run_phase(input int count, input int idle_pct);
    logic [ATTR_W-1:0]  attr;
    logic [ATTR_W-1:0]  other;
    logic [VALUE_W-1:0] value;
    int unsigned        r;
    for (int n = 0; n < count; n++) begin
      attr  = ATTR_W'($urandom_range(0, NUM_ATTRS_DEF - 1));
      other = ATTR_W'($urandom_range(0, NUM_ATTRS_DEF - 1));
      r     = $urandom_range(0, 99);
      value = {$urandom, $urandom};
      if (r < 45 && ledger.fill[attr] > 0) begin
        value = ledger.table_vals[attr][$urandom_range(0, ledger.fill[attr] - 1)];
      end else if (r < 55 && ledger.fill[other] > 0) begin
        value = ledger.table_vals[other][$urandom_range(0, ledger.fill[other] - 1)];
      end else if (r < 65) begin
        case ($urandom_range(0, 4))
          0: value = VAL_MIN;
          1: value = VAL_MAX;
          2: value = '0;
          3: value = '1;
          default: value = 64'd1;
        endcase
      end
      send_item(($urandom_range(0, 99) < 75) ? CMD_ASSIGN : CMD_LOOKUP, attr, value,
                $urandom_range(0, 99) < 12, idle_pct);
    end
  endtask

  initial begin
    cap_t start_caps [CAP_REGS];
    cap_t phase_caps [PHASES][CAP_REGS];
    int   phase_idle [PHASES];

    start_caps = '{5'd16, 5'd1, 5'd16, 5'd16};
    // Limits mostly rise from phase to phase so that assignments keep
    // happening; attribute 2 drops to 1 once to hit refusals on a full table.
    phase_caps = '{'{5'd3, 5'd2, 5'd16, 5'd1},
                   '{5'd6, 5'd4, 5'd12, 5'd5},
                   '{5'd10, 5'd9, 5'd1, 5'd8},
                   '{5'd14, 5'd16, 5'd3, 5'd12},
                   '{5'd16, 5'd16, 5'd16, 5'd16}};
    // Sender idle percentages: none, heavy, light, heavy, none.
    phase_idle = '{0, 68, 8, 68, 0};

    rst_n            <= 1'b0;
    start            <= 1'b0;
    in_cmd           <= CMD_LOOKUP;
    in_attr_id       <= '0;
    in_value         <= '0;
    in_always_assign <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_caps(start_caps);

    // Directed items: an empty table, both value extremes, a duplicate
    // assign, a capacity of one with and without always-assign, and a table
    // filled to its physical limit.
    send_item(CMD_LOOKUP, 2'd0, 64'd0, 1'b0, 0);
    send_item(CMD_ASSIGN, 2'd0, VAL_MIN, 1'b0, 0);
    send_item(CMD_ASSIGN, 2'd0, VAL_MAX, 1'b0, 0);
    send_item(CMD_LOOKUP, 2'd0, VAL_MIN, 1'b0, 0);
    send_item(CMD_ASSIGN, 2'd0, VAL_MAX, 1'b0, 0);
    send_item(CMD_ASSIGN, 2'd1, 64'd1, 1'b0, 0);
    send_item(CMD_ASSIGN, 2'd1, 64'd2, 1'b0, 0);
    send_item(CMD_ASSIGN, 2'd1, 64'd2, 1'b1, 0);
    for (int k = 0; k < VALUES_PER_ATTR_DEF; k++) begin
      send_item(CMD_ASSIGN, 2'd2, (k == 0) ? 64'd0 : (k == 1) ? '1 : {$urandom, $urandom},
                1'b1, 0);
    end
    // A full table with always-assign overflows; without it the capacity
    // check refuses first.
    send_item(CMD_ASSIGN, 2'd2, 64'd5, 1'b1, 0);
    send_item(CMD_ASSIGN, 2'd2, 64'd5, 1'b0, 0);

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      write_caps(phase_caps[p]);
      run_phase(PHASE_ITEMS, phase_idle[p]);
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (ledger.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
